>>> hdl/pen_pkg.sv
package pen_pkg;

    localparam int CW     = 16;          // coordinate width
    localparam int AW     = CW + 1;      // signed edge coefficients a, b
    localparam int UW     = CW + 1;      // magnitudes of a, b
    localparam int PW     = 2 * CW;      // cross products and |c|
    localparam int DW     = 2 * UW;      // a*a + b*b
    localparam int NW     = UW + PW;     // divider numerator
    localparam int QW     = CW + 1;      // foot coordinate magnitude
    localparam int DSW    = 2 * QW + 1;  // squared distance
    localparam int SRW    = 2 * (QW + 1);
    localparam int RTW    = QW + 1;      // root width
    localparam int RMW    = QW + 3;      // root remainder width
    localparam int SQ_STEPS = RTW;
    localparam int SQCW   = $clog2(SQ_STEPS + 1);
    localparam int DVCW   = $clog2(NW + 1);

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_FIRST,
        OP_SEL_OPEN,
        OP_SEL_CLOSE,
        OP_AB,
        OP_P,
        OP_Q,
        OP_CM,
        OP_DA,
        OP_DB,
        OP_NX,
        OP_NY,
        OP_DIV,
        OP_SVX,
        OP_SVY,
        OP_SQX,
        OP_SQY,
        OP_KEEP,
        OP_PREV,
        OP_SQ_START,
        OP_SQ_STEP,
        OP_OUT
    } op_t;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_FIRST, S_SEL, S_CSEL, S_AB, S_P, S_Q, S_CM,
        S_DA, S_DB, S_NX, S_DXS, S_DXW, S_SVX, S_NY, S_DYS, S_DYW, S_SVY,
        S_SQX, S_SQY, S_KEEP, S_PREV, S_SQS, S_SQR, S_OUT
    } state_t;

    typedef struct packed {
        op_t  op;
        logic closing;
    } dp_cmd_t;

    typedef struct packed {
        logic seen_zero;
        logic last;
        logic zero_edge;
        logic div_done;
        logic out_full;
    } dp_stat_t;

endpackage

>>> hdl/pen_div.sv
module pen_div (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  logic [pen_pkg::NW-1:0]  num,
    input  logic [pen_pkg::DW-1:0]  den,
    output logic [pen_pkg::NW-1:0]  quot,
    output logic                    done
);
    import pen_pkg::*;

    logic [DW-1:0]   rem_reg;
    logic [NW-1:0]   num_reg;
    logic [NW-1:0]   quot_reg;
    logic [DW-1:0]   den_reg;
    logic [DVCW-1:0] cnt_reg;
    logic            busy_reg;
    logic            done_reg;
    logic [DW:0]     trial;
    logic            fits;

    // restoring division, one quotient bit per cycle
    assign trial = {rem_reg, num_reg[NW-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= DVCW'(NW);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DVCW'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg  <= '0;
            num_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end else if (busy_reg) begin
            rem_reg  <= fits ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            num_reg  <= {num_reg[NW-2:0], 1'b0};
            quot_reg <= {quot_reg[NW-2:0], fits};
        end
    end

    assign quot = quot_reg;
    assign done = done_reg;
endmodule

>>> hdl/pen_datapath.sv
module pen_datapath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  pen_pkg::dp_cmd_t              cmd,
    output pen_pkg::dp_stat_t             stat,
    input  logic signed [pen_pkg::CW-1:0] s_vertex_x,
    input  logic signed [pen_pkg::CW-1:0] s_vertex_y,
    input  logic                          s_is_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [pen_pkg::CW:0]   m_near_x,
    output logic signed [pen_pkg::CW:0]   m_near_y,
    output logic [pen_pkg::CW-1:0]        m_distance,
    output logic                          m_status
);
    import pen_pkg::*;

    logic signed [CW-1:0] in_x_reg, in_y_reg, first_x_reg, first_y_reg;
    logic signed [CW-1:0] prev_x_reg, prev_y_reg;
    logic signed [CW-1:0] x1_reg, y1_reg, x2_reg, y2_reg;
    logic                 in_last_reg;
    logic signed [AW-1:0] a_reg, b_reg;
    logic signed [PW-1:0] p_reg, q_reg;
    logic [PW-1:0]        cm_reg;
    logic                 cneg_reg;
    logic [DW-1:0]        den_reg;
    logic [NW-1:0]        num_reg;
    logic [QW-1:0]        qx_reg, qy_reg;
    logic [DSW-1:0]       sq_reg, d2_reg, best_d2_reg;
    logic signed [QW:0]   best_px_reg, best_py_reg;
    logic                 have_best_reg;
    logic [1:0]           seen_reg;
    logic [SRW-1:0]       rad_reg;
    logic [RMW-1:0]       rem_reg;
    logic [RTW-1:0]       root_reg;
    logic                 m_valid_reg;

    logic [UW-1:0]        ua, ub;
    logic signed [PW:0]   pq;
    logic [NW-1:0]        quot;
    logic                 div_done;
    logic signed [QW:0]   px_w, py_w;
    logic                 upd;
    logic [RMW-1:0]       rem2, trial;

    assign ua = a_reg[AW-1] ? UW'(-a_reg) : UW'(a_reg);
    assign ub = b_reg[AW-1] ? UW'(-b_reg) : UW'(b_reg);
    assign pq = {p_reg[PW-1], p_reg} - {q_reg[PW-1], q_reg};

    // foot sign: negative when sign of the coefficient matches sign of c
    assign px_w = (a_reg[AW-1] == cneg_reg) ? -$signed({1'b0, qx_reg})
                                             : $signed({1'b0, qx_reg});
    assign py_w = (b_reg[AW-1] == cneg_reg) ? -$signed({1'b0, qy_reg})
                                             : $signed({1'b0, qy_reg});
    // closing edge also wins ties
    assign upd = !have_best_reg ||
                 (cmd.closing ? (d2_reg <= best_d2_reg) : (d2_reg < best_d2_reg));

    assign rem2  = {rem_reg[RMW-3:0], rad_reg[SRW-1:SRW-2]};
    assign trial = {root_reg, 2'b01};

    pen_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.op == OP_DIV),
        .num     (num_reg),
        .den     (den_reg),
        .quot    (quot),
        .done    (div_done)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg      <= '0;
            have_best_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.op == OP_OUT) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (cmd.op)
                OP_FIRST: have_best_reg <= 1'b0;
                OP_KEEP:  if (upd) have_best_reg <= 1'b1;
                OP_PREV:  if (seen_reg != 2'd2) seen_reg <= seen_reg + 1'b1;
                OP_OUT: begin
                    seen_reg      <= '0;
                    have_best_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        case (cmd.op)
            OP_LOAD: begin
                in_x_reg    <= s_vertex_x;
                in_y_reg    <= s_vertex_y;
                in_last_reg <= s_is_last;
            end
            OP_FIRST: begin
                first_x_reg <= in_x_reg;
                first_y_reg <= in_y_reg;
                best_d2_reg <= '0;
                best_px_reg <= '0;
                best_py_reg <= '0;
            end
            OP_SEL_OPEN: begin
                x1_reg <= prev_x_reg;
                y1_reg <= prev_y_reg;
                x2_reg <= in_x_reg;
                y2_reg <= in_y_reg;
            end
            OP_SEL_CLOSE: begin
                x1_reg <= prev_x_reg;
                y1_reg <= prev_y_reg;
                x2_reg <= first_x_reg;
                y2_reg <= first_y_reg;
            end
            OP_AB: begin
                a_reg <= AW'(y1_reg) - AW'(y2_reg);
                b_reg <= AW'(x2_reg) - AW'(x1_reg);
            end
            OP_P: p_reg <= PW'(x1_reg) * PW'(y2_reg);
            OP_Q: q_reg <= PW'(x2_reg) * PW'(y1_reg);
            OP_CM: begin
                cneg_reg <= pq[PW];
                cm_reg   <= pq[PW] ? PW'(-pq) : pq[PW-1:0];
            end
            OP_DA: den_reg <= DW'(ua) * DW'(ua);
            OP_DB: den_reg <= den_reg + DW'(ub) * DW'(ub);
            OP_NX: num_reg <= NW'(ua) * NW'(cm_reg);
            OP_NY: num_reg <= NW'(ub) * NW'(cm_reg);
            OP_SVX: qx_reg <= quot[QW-1:0];
            OP_SVY: qy_reg <= quot[QW-1:0];
            OP_SQX: sq_reg <= DSW'(qx_reg) * DSW'(qx_reg);
            OP_SQY: d2_reg <= sq_reg + DSW'(qy_reg) * DSW'(qy_reg);
            OP_KEEP: if (upd) begin
                best_d2_reg <= d2_reg;
                best_px_reg <= px_w;
                best_py_reg <= py_w;
            end
            OP_PREV: begin
                prev_x_reg <= in_x_reg;
                prev_y_reg <= in_y_reg;
            end
            OP_SQ_START: begin
                rad_reg  <= have_best_reg ? SRW'(best_d2_reg) : '0;
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQ_STEP: begin
                rad_reg <= {rad_reg[SRW-3:0], 2'b00};
                if (rem2 >= trial) begin
                    rem_reg  <= rem2 - trial;
                    root_reg <= {root_reg[RTW-2:0], 1'b1};
                end else begin
                    rem_reg  <= rem2;
                    root_reg <= {root_reg[RTW-2:0], 1'b0};
                end
            end
            OP_OUT: begin
                m_near_x   <= best_px_reg[CW:0];
                m_near_y   <= best_py_reg[CW:0];
                m_distance <= root_reg[CW-1:0];
                m_status   <= !have_best_reg;
            end
            default: ;
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign stat.seen_zero = (seen_reg == 2'd0);
    assign stat.last      = in_last_reg;
    assign stat.zero_edge = (x1_reg == x2_reg) && (y1_reg == y2_reg);
    assign stat.div_done  = div_done;
    assign stat.out_full  = m_valid_reg && !m_ready;
endmodule

>>> hdl/pen_ctrl.sv
module pen_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  pen_pkg::dp_stat_t  stat,
    output pen_pkg::dp_cmd_t   cmd
);
    import pen_pkg::*;

    state_t          state_reg, state_next;
    logic            closing_reg, closing_next;
    logic [SQCW-1:0] sq_cnt_reg, sq_cnt_next;
    state_t          edge_end;

    assign edge_end = closing_reg ? S_SQS : S_PREV;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            closing_reg <= 1'b0;
            sq_cnt_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            closing_reg <= closing_next;
            sq_cnt_reg  <= sq_cnt_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        closing_next = closing_reg;
        sq_cnt_next  = sq_cnt_reg;
        case (state_reg)
            S_IDLE:  if (s_valid) state_next = S_START;
            S_START: state_next = stat.seen_zero ? S_FIRST : S_SEL;
            S_FIRST: state_next = S_PREV;
            S_SEL: begin
                closing_next = 1'b0;
                state_next   = S_AB;
            end
            S_CSEL: begin
                closing_next = 1'b1;
                state_next   = S_AB;
            end
            S_AB:    state_next = stat.zero_edge ? edge_end : S_P;
            S_P:     state_next = S_Q;
            S_Q:     state_next = S_CM;
            S_CM:    state_next = S_DA;
            S_DA:    state_next = S_DB;
            S_DB:    state_next = S_NX;
            S_NX:    state_next = S_DXS;
            S_DXS:   state_next = S_DXW;
            S_DXW:   if (stat.div_done) state_next = S_SVX;
            S_SVX:   state_next = S_NY;
            S_NY:    state_next = S_DYS;
            S_DYS:   state_next = S_DYW;
            S_DYW:   if (stat.div_done) state_next = S_SVY;
            S_SVY:   state_next = S_SQX;
            S_SQX:   state_next = S_SQY;
            S_SQY:   state_next = S_KEEP;
            S_KEEP:  state_next = edge_end;
            S_PREV:  state_next = stat.last ? S_CSEL : S_IDLE;
            S_SQS: begin
                sq_cnt_next = SQCW'(SQ_STEPS);
                state_next  = S_SQR;
            end
            S_SQR: begin
                sq_cnt_next = sq_cnt_reg - 1'b1;
                if (sq_cnt_reg == SQCW'(1)) state_next = S_OUT;
            end
            S_OUT:   if (!stat.out_full) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.op      = OP_NONE;
        cmd.closing = closing_reg;
        case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = OP_LOAD;
            end
            S_FIRST: cmd.op = OP_FIRST;
            S_SEL:   cmd.op = OP_SEL_OPEN;
            S_CSEL:  cmd.op = OP_SEL_CLOSE;
            S_AB:    cmd.op = OP_AB;
            S_P:     cmd.op = OP_P;
            S_Q:     cmd.op = OP_Q;
            S_CM:    cmd.op = OP_CM;
            S_DA:    cmd.op = OP_DA;
            S_DB:    cmd.op = OP_DB;
            S_NX:    cmd.op = OP_NX;
            S_DXS:   cmd.op = OP_DIV;
            S_SVX:   cmd.op = OP_SVX;
            S_NY:    cmd.op = OP_NY;
            S_DYS:   cmd.op = OP_DIV;
            S_SVY:   cmd.op = OP_SVY;
            S_SQX:   cmd.op = OP_SQX;
            S_SQY:   cmd.op = OP_SQY;
            S_KEEP:  cmd.op = OP_KEEP;
            S_PREV:  cmd.op = OP_PREV;
            S_SQS:   cmd.op = OP_SQ_START;
            S_SQR:   cmd.op = OP_SQ_STEP;
            S_OUT:   if (!stat.out_full) cmd.op = OP_OUT;
            default: cmd.op = OP_NONE;
        endcase
    end
endmodule

>>> hdl/polygon_edge_nearest_point.sv
// channel  | ports                                        | dir
// ---------+----------------------------------------------+-----
// vertex   | s_valid s_ready s_vertex_x s_vertex_y s_is_last | in
// result   | m_valid m_ready m_near_x m_near_y m_distance m_status | out
//
// One vertex transaction at a time. A vertex with a nonzero edge runs through the
// edge states and two passes of the shared bit-serial divider; the last vertex
// adds the closing edge and an RTW-step root.
// Synchronous active-low reset on aresetn clears the controller and counts.
// A stalled result is held in the output register; a finished polygon waits
// for it to drain before loading the next result.
module polygon_edge_nearest_point (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [pen_pkg::CW-1:0] s_vertex_x,
    input  logic signed [pen_pkg::CW-1:0] s_vertex_y,
    input  logic                          s_is_last,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [pen_pkg::CW:0]   m_near_x,
    output logic signed [pen_pkg::CW:0]   m_near_y,
    output logic [pen_pkg::CW-1:0]        m_distance,
    output logic                          m_status
);
    import pen_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    pen_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    pen_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .s_vertex_x (s_vertex_x),
        .s_vertex_y (s_vertex_y),
        .s_is_last  (s_is_last),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_near_x   (m_near_x),
        .m_near_y   (m_near_y),
        .m_distance (m_distance),
        .m_status   (m_status)
    );
endmodule
